### hdl/wbps_pkg.sv
package wbps_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;

	// Register widths and reset values
	localparam int unsigned CFG_DATA_W   = 64;
	localparam int unsigned CARE_W       = 16;
	localparam int unsigned LEN_W        = 5;
	localparam int unsigned POS_W        = 32;
	localparam int unsigned REG_BYTES    = 16;
	localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;
	localparam logic [POS_W-1:0]  POS_MAX    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} wbps_in_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_offset;
	} wbps_out_t;

	// Control handed from the top level to every cell
	typedef struct packed {
		logic shift;
		logic clear;
	} wbps_cell_ctrl_t;

endpackage

### hdl/wbps_cell.sv
module wbps_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  wbps_pkg::wbps_cell_ctrl_t ctrl,
	input  logic                     prev_bit,
	input  logic [7:0]               data_byte,
	input  logic [7:0]               pattern_byte,
	input  logic                     care,
	output logic                     next_bit,
	output logic                     prefix_bit
);

	logic prefix_q;

	// A position matches when it is a wildcard or the bytes agree, and the
	// shorter prefix held by the neighbour matched one byte earlier.
	assign next_bit   = prev_bit & (~care | (data_byte == pattern_byte));
	assign prefix_bit = prefix_q;

	// Prefix bit of this position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
		end else if (ctrl.clear) begin
			prefix_q <= 1'b0;
		end else if (ctrl.shift) begin
			prefix_q <= next_bit;
		end
	end

endmodule

### hdl/wildcard_byte_pattern_scan.sv
// Channel  Direction  Payload                          Transfer when
// in       input      wbps_in_t  (data_byte, last)     in_valid  & in_ready
// out      output     wbps_out_t (found, offset)       out_valid & out_ready
// cfg      input      cfg_index, cfg_data              cfg_valid & cfg_ready
//
// One byte is taken per cycle while in_ready is high; its result, if any,
// appears in the output register in the cycle after the transfer.
// Until a match, the cells update every prefix bit in the same cycle the byte arrives.
// A waiting result stalls the input only when out_ready is low at that time.
// The configuration port is always ready. Reset clears the scan state and
// loads the register reset values.
module wildcard_byte_pattern_scan #(
	parameter int unsigned PATTERN_MAX = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  wbps_pkg::wbps_in_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output wbps_pkg::wbps_out_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int unsigned EXT_W = 8;

	logic [wbps_pkg::CFG_DATA_W-1:0] pattern_low_q;
	logic [wbps_pkg::CFG_DATA_W-1:0] pattern_high_q;
	logic [wbps_pkg::CARE_W-1:0]     care_mask_q;
	logic [wbps_pkg::LEN_W-1:0]      pattern_len_q;

	logic [wbps_pkg::POS_W-1:0]      byte_pos_q;
	logic                            reported_q;
	logic                            out_valid_q;
	wbps_pkg::wbps_out_t             out_data_q;

	logic                            in_fire;
	wbps_pkg::wbps_cell_ctrl_t       cell_ctrl;
	logic [PATTERN_MAX-1:0]          next_vec;
	logic [PATTERN_MAX-1:0]          prefix_vec;
	logic [EXT_W-1:0]                len_ext;
	logic [EXT_W-1:0]                len_eff;
	logic [EXT_W-1:0]                len_m1;
	logic [IDX_W-1:0]                sel_idx;
	logic                            match;
	logic                            result_valid;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign in_ready  = ~out_valid_q | out_ready;
	assign in_fire   = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			care_mask_q    <= wbps_pkg::CARE_RESET;
			pattern_len_q  <= wbps_pkg::LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				wbps_pkg::CFG_PATTERN_LOW: begin
					pattern_low_q <= cfg_data;
				end
				wbps_pkg::CFG_PATTERN_HIGH: begin
					pattern_high_q <= cfg_data;
				end
				wbps_pkg::CFG_CARE_MASK: begin
					care_mask_q <= cfg_data[wbps_pkg::CARE_W-1:0];
				end
				wbps_pkg::CFG_PATTERN_LEN: begin
					pattern_len_q <= cfg_data[wbps_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Cells shift only while the region has not yet reported a match.
	assign cell_ctrl.shift = in_fire & ~reported_q;
	assign cell_ctrl.clear = in_fire & in_data.last_byte;

	// Row of cells, one per pattern position.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic       prev;
		logic [7:0] pbyte;
		logic       pcare;

		if (k == 0) begin : g_first
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = prefix_vec[k-1];
		end

		if (k < 8) begin : g_low
			assign pbyte = pattern_low_q[8*k +: 8];
			assign pcare = care_mask_q[k];
		end else if (k < wbps_pkg::REG_BYTES) begin : g_high
			assign pbyte = pattern_high_q[8*(k-8) +: 8];
			assign pcare = care_mask_q[k];
		end else begin : g_wild
			// Positions beyond the pattern registers always match.
			assign pbyte = 8'h00;
			assign pcare = 1'b0;
		end

		wbps_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (cell_ctrl),
			.prev_bit     (prev),
			.data_byte    (in_data.data_byte),
			.pattern_byte (pbyte),
			.care         (pcare),
			.next_bit     (next_vec[k]),
			.prefix_bit   (prefix_vec[k])
		);
	end

	// Effective length: zero counts as one, and it is capped at the row size.
	always_comb begin
		len_ext = {{(EXT_W-wbps_pkg::LEN_W){1'b0}}, pattern_len_q};
		if (len_ext == '0) begin
			len_eff = EXT_W'(1);
		end else if (len_ext > EXT_W'(PATTERN_MAX)) begin
			len_eff = EXT_W'(PATTERN_MAX);
		end else begin
			len_eff = len_ext;
		end
		len_m1  = len_eff - EXT_W'(1);
		sel_idx = len_m1[IDX_W-1:0];
	end

	assign match        = next_vec[sel_idx];
	assign result_valid = cell_ctrl.shift & (match | in_data.last_byte);

	// Region position and report flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			reported_q <= 1'b0;
		end else if (in_fire) begin
			if (in_data.last_byte) begin
				byte_pos_q <= '0;
				reported_q <= 1'b0;
			end else begin
				if (byte_pos_q != wbps_pkg::POS_MAX) begin
					byte_pos_q <= byte_pos_q + wbps_pkg::POS_W'(1);
				end
				if (cell_ctrl.shift && match) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= result_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_fire && result_valid) begin
			out_data_q.found <= match;
			if (match) begin
				out_data_q.match_offset <= byte_pos_q
					- {{(wbps_pkg::POS_W-EXT_W){1'b0}}, len_m1};
			end else begin
				out_data_q.match_offset <= '0;
			end
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned RANDOM_BYTES = 1150;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned TAIL_CYCLES  = 4;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	wbps_pkg::wbps_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	wbps_pkg::wbps_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index = wbps_pkg::CFG_PATTERN_LOW;
	logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	wildcard_byte_pattern_scan dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Register image held by the scan predictor.
	logic [wbps_pkg::CFG_DATA_W-1:0] pat_lo = '0;
	logic [wbps_pkg::CFG_DATA_W-1:0] pat_hi = '0;
	logic [wbps_pkg::CARE_W-1:0] care = wbps_pkg::CARE_RESET;
	logic [wbps_pkg::LEN_W-1:0] pat_len = wbps_pkg::LEN_RESET;

	// Scan state of the predictor.
	logic [wbps_pkg::REG_BYTES-1:0] prefix = '0;
	logic [wbps_pkg::POS_W-1:0] pos = '0;
	bit seen_match = 1'b0;

	wbps_pkg::wbps_in_t pending[$];
	wbps_pkg::wbps_out_t expected_results[$];

	// Pacing and bookkeeping.
	bit calm = 1'b1;
	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned cycles = 0;
	int unsigned bytes_scanned = 0;
	int unsigned results_seen = 0;
	int unsigned matches_seen = 0;
	int unsigned settings_written = 0;
	int unsigned mismatches = 0;

	// Stimulus shaping for the current setting.
	logic [7:0] alphabet[4];
	bit use_alpha = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] pattern_byte(int unsigned k);
		return (k < 8) ? pat_lo[k*8 +: 8] : pat_hi[(k-8)*8 +: 8];
	endfunction

	// Zero counts as one and anything past the register bytes as sixteen.
	function automatic int unsigned eff_len();
		if (pat_len == 0)
			return 1;
		if (pat_len > wbps_pkg::REG_BYTES)
			return wbps_pkg::REG_BYTES;
		return pat_len;
	endfunction

	// Shift-and step over one byte; returns 1 when the byte causes a result.
	function automatic bit scan_byte(input wbps_pkg::wbps_in_t it,
			output wbps_pkg::wbps_out_t res);
		logic [wbps_pkg::REG_BYTES-1:0] hits;
		int unsigned len;
		int unsigned k;
		bit got;
		got = 1'b0;
		res = '0;
		if (!seen_match) begin
			len = eff_len();
			for (k = 0; k < wbps_pkg::REG_BYTES; k++)
				hits[k] = !care[k] || (pattern_byte(k) == it.data_byte);
			prefix = {prefix[wbps_pkg::REG_BYTES-2:0], 1'b1} & hits;
			if (prefix[len-1]) begin
				res.found = 1'b1;
				res.match_offset = pos - wbps_pkg::POS_W'(len - 1);
				seen_match = 1'b1;
				got = 1'b1;
			end else if (it.last_byte) begin
				got = 1'b1;
			end
		end
		if (pos != wbps_pkg::POS_MAX)
			pos++;
		if (it.last_byte) begin
			prefix = '0;
			pos = '0;
			seen_match = 1'b0;
		end
		return got;
	endfunction

	function automatic int unsigned draw_gap();
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	task automatic log_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0d] mismatch: %s", cycles, what);
	endtask

	task automatic push_byte(logic [7:0] b, logic last);
		wbps_pkg::wbps_in_t it;
		it.data_byte = b;
		it.last_byte = last;
		pending.insert(pending.size(), it);
	endtask

	// A region of random bytes, usually with the pattern planted somewhere in it,
	// and now and then with one bit of the planted copy spoilt.
	task automatic push_region(int unsigned n, bit close);
		logic [7:0] bytes[$];
		int unsigned len;
		int unsigned at;
		int unsigned k;
		len = eff_len();
		for (k = 0; k < n; k++) begin
			if (use_alpha && $urandom_range(0, 3) != 0)
				bytes.insert(bytes.size(), alphabet[$urandom_range(0, 3)]);
			else
				bytes.insert(bytes.size(), 8'($urandom));
		end
		if (n >= len && $urandom_range(0, 3) != 0) begin
			at = $urandom_range(0, n - len);
			for (k = 0; k < len; k++)
				if (care[k])
					bytes[at+k] = pattern_byte(k);
			if ($urandom_range(0, 3) == 0)
				bytes[at + $urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
		end
		for (k = 0; k < n; k++)
			push_byte(bytes[k], close && (k == n - 1));
	endtask

	// Valid is left high between back-to-back writes and lowered by the caller.
	task automatic write_reg(logic [wbps_pkg::CFG_IDX_W-1:0] idx,
			logic [wbps_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			wbps_pkg::CFG_PATTERN_LOW: pat_lo = val;
			wbps_pkg::CFG_PATTERN_HIGH: pat_hi = val;
			wbps_pkg::CFG_CARE_MASK: care = val[wbps_pkg::CARE_W-1:0];
			wbps_pkg::CFG_PATTERN_LEN: pat_len = val[wbps_pkg::LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(logic [63:0] lo, logic [63:0] hi, logic [15:0] cm,
			logic [4:0] ln);
		@(posedge clk);
		write_reg(wbps_pkg::CFG_PATTERN_LOW, lo);
		write_reg(wbps_pkg::CFG_PATTERN_HIGH, hi);
		write_reg(wbps_pkg::CFG_CARE_MASK, 64'(cm));
		write_reg(wbps_pkg::CFG_PATTERN_LEN, 64'(ln));
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	// Waits until every queued byte has gone in and every result has come out,
	// then lets the last byte drain through the block.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Sender: presents queued bytes and predicts on every transfer.
	always @(posedge clk) begin : sender
		wbps_pkg::wbps_out_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				bytes_scanned++;
				if (scan_byte(in_data, res))
					expected_results.insert(expected_results.size(), res);
				send_wait = draw_gap();
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					in_data <= pending.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer and paces out_ready.
	always @(posedge clk) begin : receiver
		wbps_pkg::wbps_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.found)
					matches_seen++;
				if (expected_results.size() == 0) begin
					log_mismatch($sformatf("unexpected result found=%0b offset=%0d",
						out_data.found, out_data.match_offset));
				end else begin
					want = expected_results.pop_front();
					if (out_data.found !== want.found ||
							out_data.match_offset !== want.match_offset)
						log_mismatch($sformatf(
							"expected found=%0b offset=%0d, got found=%0b offset=%0d",
							want.found, want.match_offset,
							out_data.found, out_data.match_offset));
				end
				recv_wait = draw_gap();
			end
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				recv_wait = LONG_HOLD;
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned start;
		int unsigned queued;
		int unsigned n;
		int unsigned k;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] cm;
		logic [4:0] ln;
		bit squeeze;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset setting: a match at offset zero, bytes after a match ignored,
		// a one-byte region with no match, and a match on the last byte.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b1);
		wait_idle();

		// A length of zero behaves as one.
		load_setting(64'h0000_0000_0000_00FF, '0, 16'hFFFF, 5'd0);
		push_byte(8'hFF, 1'b1);
		wait_idle();

		// An oversized length behaves as sixteen; a short region cannot match.
		load_setting('1, '1, 16'hFFFF, 5'd31);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		wait_idle();

		// Wildcard in the second position, then a setting change in mid-region.
		load_setting(64'h0000_0000_4433_2211, 64'h0123_4567_89AB_CDEF, 16'h000D, 5'd4);
		push_byte(8'h11, 1'b0);
		push_byte(8'h99, 1'b0);
		push_byte(8'h33, 1'b0);
		push_byte(8'h44, 1'b1);
		push_byte(8'h11, 1'b0);
		push_byte(8'h22, 1'b0);
		wait_idle();
		load_setting(64'h0000_0000_4433_2211, 64'h0123_4567_89AB_CDEF, 16'hFFFF, 5'd4);
		push_byte(8'h33, 1'b0);
		push_byte(8'h44, 1'b1);
		wait_idle();

		// Random settings, each followed by a batch of regions.
		start = bytes_scanned;
		phase = 0;
		while (bytes_scanned - start < RANDOM_BYTES) begin
			squeeze = (phase == 2);
			use_alpha = ($urandom_range(0, 2) != 0);
			for (k = 0; k < 4; k++)
				alphabet[k] = ($urandom_range(0, 3) == 0) ? {8{k[0]}} : 8'($urandom);
			if (use_alpha) begin
				for (k = 0; k < 8; k++) begin
					lo[k*8 +: 8] = alphabet[$urandom_range(0, 3)];
					hi[k*8 +: 8] = alphabet[$urandom_range(0, 3)];
				end
			end else begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end
			case ($urandom_range(0, 5))
				0: cm = '0;
				1: cm = '1;
				default: cm = 16'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: ln = 5'd0;
				1: ln = 5'd1;
				2: ln = 5'd16;
				3: ln = 5'($urandom_range(17, 31));
				4: ln = 5'd31;
				default: ln = 5'($urandom_range(1, 16));
			endcase
			if (squeeze) begin
				cm = '0;
				ln = 5'd1;
			end
			load_setting(lo, hi, cm, ln);
			calm = squeeze || ($urandom_range(0, 4) == 0);

			// Every byte matches here, so results pile up behind the held receiver.
			if (squeeze)
				hold_asks++;

			queued = 0;
			while (queued < 40) begin
				if (squeeze || $urandom_range(0, 5) == 0)
					n = $urandom_range(1, 4);
				else
					n = $urandom_range(1, eff_len() + 20);
				push_region(n, 1'b1);
				queued += n;
			end
			// Sometimes leave a region open across the next setting change.
			if ($urandom_range(0, 3) == 0)
				push_region($urandom_range(1, 8), 1'b0);
			wait_idle();
			phase++;
		end

		wait_idle();
		$display("Scanned %0d bytes under %0d register settings, one long output stall.",
			bytes_scanned, settings_written + 1);
		$display("Checked %0d results (%0d matches); %0d mismatches.",
			results_seen, matches_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
hdl/wbps_pkg.sv
hdl/wbps_cell.sv
hdl/wildcard_byte_pattern_scan.sv
sim/tb.sv
